// ===== design/rhr_pkg.sv =====
`timescale 1ns / 1ps
package rhr_pkg;

   // pipeline geometry
   localparam int DIV_BITS = 8;
   localparam int LATENCY  = 20;
   localparam int CAR_LEN  = 10;

   // hue sector offsets, one sector below the nominal base so the
   // divider numerator never goes negative
   localparam logic [9:0] HOFF_RED   = 10'd300;
   localparam logic [9:0] HOFF_GREEN = 10'd420;
   localparam logic [9:0] HOFF_BLUE  = 10'd540;
   localparam logic [9:0] HUE_FULL   = 10'd360;
   localparam logic [5:0] SECTOR_DEG = 6'd60;

   // floor(x / 15300) and floor(x / 360) by reciprocal
   localparam logic [13:0] SCALE_DIV   = 14'd15300;
   localparam logic [18:0] SCALE_RECIP = 19'd280716;
   localparam logic [15:0] HUE_RECIP   = 16'd46603;

   typedef struct packed {
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic [15:0] shift;
      logic [7:0]  mx;
      logic [9:0]  hoff;
      logic        gray;
   } pix_type;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] mx;
      logic [7:0] sat;
      logic [2:0] sec;
      logic       gray;
   } car_type;

endpackage

// ===== design/rhr_ifs.sv =====
`timescale 1ns / 1ps
interface rhr_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  red_in;
   logic [7:0]  green_in;
   logic [7:0]  blue_in;
   logic [15:0] hue_shift;
   modport source (output valid, red_in, green_in, blue_in, hue_shift, input ready);
   modport sink (input valid, red_in, green_in, blue_in, hue_shift, output ready);
endinterface

interface rhr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   modport source (output valid, red_out, green_out, blue_out, input ready);
   modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

// ===== design/rhr_div.sv =====
`timescale 1ns / 1ps
module rhr_div (
   input  logic        clock,
   input  logic        en,
   input  logic [15:0] num,
   input  logic [7:0]  den,
   output logic [7:0]  quo
);

   logic [15:0] rem_ff [rhr_pkg::DIV_BITS];
   logic [7:0]  den_ff [rhr_pkg::DIV_BITS];
   logic [7:0]  quo_ff [rhr_pkg::DIV_BITS];
   logic [15:0] rem_in [rhr_pkg::DIV_BITS];
   logic [7:0]  den_in [rhr_pkg::DIV_BITS];
   logic [7:0]  quo_in [rhr_pkg::DIV_BITS];

   // one restoring step per stage, most significant quotient bit first
   always_comb begin
      logic [15:0] rem_prev;
      logic [7:0]  den_prev;
      logic [7:0]  quo_prev;
      logic [15:0] dsh;
      for (int i = 0; i < rhr_pkg::DIV_BITS; i++) begin
         rem_prev = (i == 0) ? num : rem_ff[(i == 0) ? 0 : i - 1];
         den_prev = (i == 0) ? den : den_ff[(i == 0) ? 0 : i - 1];
         quo_prev = (i == 0) ? 8'd0 : quo_ff[(i == 0) ? 0 : i - 1];
         dsh = 16'(den_prev) << (rhr_pkg::DIV_BITS - 1 - i);
         den_in[i] = den_prev;
         if (rem_prev >= dsh) begin
            rem_in[i] = rem_prev - dsh;
            quo_in[i] = {quo_prev[6:0], 1'b1};
         end else begin
            rem_in[i] = rem_prev;
            quo_in[i] = {quo_prev[6:0], 1'b0};
         end
      end
   end

   // advance all stages together
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < rhr_pkg::DIV_BITS; i++) begin
            rem_ff[i] <= rem_in[i];
            den_ff[i] <= den_in[i];
            quo_ff[i] <= quo_in[i];
         end
      end
   end

   assign quo = quo_ff[rhr_pkg::DIV_BITS - 1];

endmodule

// ===== design/rhr_cdiv.sv =====
`timescale 1ns / 1ps
module rhr_cdiv (
   input  logic        clock,
   input  logic        en,
   input  logic [21:0] x,
   output logic [7:0]  q
);

   logic [40:0] prod_ff, prod_in;
   logic [21:0] x1_ff, x2_ff;
   logic [7:0]  q0_ff, q0_in;
   logic [21:0] qm;
   logic [21:0] rem;
   logic [7:0]  q_ff, q_in;

   // estimate by reciprocal, low by at most one
   assign prod_in = 41'(x) * 41'(rhr_pkg::SCALE_RECIP);
   assign q0_in   = prod_ff[39:32];
   assign qm      = 22'(q0_ff) * 22'(rhr_pkg::SCALE_DIV);

   // correct the estimate with one compare
   assign rem  = x2_ff - qm;
   assign q_in = (rem >= 22'(rhr_pkg::SCALE_DIV)) ? q0_ff + 8'd1 : q0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         x1_ff   <= x;
         q0_ff   <= q0_in;
         x2_ff   <= x1_ff;
         q_ff    <= q_in;
      end
   end

   assign q = q_ff;

endmodule

// ===== design/rgb_hue_rotate_top.sv =====
`timescale 1ns / 1ps
// RGB hue rotation pipeline.
// req channel carries one pixel (red_in, green_in, blue_in) and a hue
// shift in degrees; rsp channel returns the rotated pixel, one item out
// for every item in, in order. Both are valid/ready channels; an item
// moves at a clock edge where valid and ready are both high.
// Throughput is one pixel per clock while rsp is not stalled: the pipeline
// has 20 register stages, two 8-stage restoring dividers (saturation and
// hue) run side by side, and the back conversion uses reciprocal
// multiplies for the constant divides.
// Gray pixels pass through unchanged.
// Synchronous reset empties the pipeline; no item is lost at reset
// apart from those in flight. When the receiver holds rsp ready low
// with a result waiting, the whole pipeline holds and req ready drops
// in the same cycle; nothing is dropped or repeated.
module rgb_hue_rotate_top (
   input logic clock,
   input logic reset,
   rhr_req_if.sink   req,
   rhr_rsp_if.source rsp
);

   localparam int L = rhr_pkg::LATENCY;

   logic en;
   logic vld_ff [L];

   // stage 0: extremes, hue numerator, sector offset
   logic [7:0]  r, g, b, mx, mn, d, x, y;
   logic        rmax, gmax;
   logic [15:0] diff;
   rhr_pkg::pix_type pix_in;
   rhr_pkg::pix_type pix_ff [rhr_pkg::DIV_BITS + 1];
   logic [15:0] hnum_ff, hnum_in, snum_ff, snum_in;
   logic [7:0]  hq, sq;

   assign r = req.red_in;
   assign g = req.green_in;
   assign b = req.blue_in;

   always_comb begin
      rmax = (r >= g) && (r >= b);
      gmax = !rmax && (g >= b);
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      pix_in.r     = r;
      pix_in.g     = g;
      pix_in.b     = b;
      pix_in.shift = req.hue_shift;
      pix_in.mx    = mx;
      pix_in.gray  = (r == g) && (g == b);
      if (rmax) begin
         x = g;
         y = b;
         pix_in.hoff = rhr_pkg::HOFF_RED;
      end else if (gmax) begin
         x = b;
         y = r;
         pix_in.hoff = rhr_pkg::HOFF_GREEN;
      end else begin
         x = r;
         y = g;
         pix_in.hoff = rhr_pkg::HOFF_BLUE;
      end
      diff    = 16'(x) + 16'(d) - 16'(y);
      hnum_in = 16'(diff * 16'(rhr_pkg::SECTOR_DEG));
      snum_in = 16'(16'(d) * 16'd255);
   end

   logic [7:0] hnum_d_ff;

   rhr_div u_hdiv (.clock(clock), .en(en), .num(hnum_ff), .den(hnum_d_ff), .quo(hq));
   rhr_div u_sdiv (.clock(clock), .en(en), .num(snum_ff), .den(pix_ff[0].mx), .quo(sq));

   // stage 9: hue in 0..359 plus shift, wrapped to 16 bits
   logic [9:0]  hue0, huew;
   logic [15:0] hsum_ff, hsum_in, hsum10_ff, hsum11_ff;
   rhr_pkg::car_type car_ff [rhr_pkg::CAR_LEN];
   rhr_pkg::car_type car_in [rhr_pkg::CAR_LEN];

   always_comb begin
      hue0    = pix_ff[rhr_pkg::DIV_BITS].hoff + 10'(hq);
      huew    = (hue0 >= rhr_pkg::HUE_FULL) ? hue0 - rhr_pkg::HUE_FULL : hue0;
      hsum_in = 16'(huew) + pix_ff[rhr_pkg::DIV_BITS].shift;
   end

   // stages 10..12: reduce modulo 360 by reciprocal
   logic [31:0] hprod_ff, hprod_in;
   logic [16:0] hmul_ff, hmul_in, hrem;
   logic [8:0]  hue_ff, hue_in;

   assign hprod_in = 32'(hsum_ff) * 32'(rhr_pkg::HUE_RECIP);
   assign hmul_in  = 17'(hprod_ff[31:24]) * 17'd360;
   assign hrem     = {1'b0, hsum11_ff} - hmul_ff;
   assign hue_in   = (hrem >= 17'(rhr_pkg::HUE_FULL)) ? 9'(hrem - 17'(rhr_pkg::HUE_FULL))
                                                      : 9'(hrem);

   // stage 13: sector and fraction
   logic [2:0] sec_in;
   logic [5:0] frac_ff, frac_in;

   always_comb begin
      if (hue_ff < 9'd60)       sec_in = 3'd0;
      else if (hue_ff < 9'd120) sec_in = 3'd1;
      else if (hue_ff < 9'd180) sec_in = 3'd2;
      else if (hue_ff < 9'd240) sec_in = 3'd3;
      else if (hue_ff < 9'd300) sec_in = 3'd4;
      else                      sec_in = 3'd5;
      frac_in = 6'(hue_ff - 9'(9'(sec_in) * 9'd60));
   end

   // stage 14: scale factors out of 15300
   logic [13:0] pk_ff, qk_ff, tk_ff, pk_in, qk_in, tk_in;
   logic [7:0]  sat4;

   always_comb begin
      sat4  = car_ff[4].sat;
      pk_in = 14'(14'd60 * (14'd255 - 14'(sat4)));
      qk_in = 14'(rhr_pkg::SCALE_DIV - 14'(14'(sat4) * 14'(frac_ff)));
      tk_in = 14'(rhr_pkg::SCALE_DIV - 14'(14'(sat4) * 14'(6'd60 - frac_ff)));
   end

   // stage 15: value times factor
   logic [21:0] px_ff, qx_ff, tx_ff;
   logic [7:0]  pv, qv, tv;

   rhr_cdiv u_pdiv (.clock(clock), .en(en), .x(px_ff), .q(pv));
   rhr_cdiv u_qdiv (.clock(clock), .en(en), .x(qx_ff), .q(qv));
   rhr_cdiv u_tdiv (.clock(clock), .en(en), .x(tx_ff), .q(tv));

   // carry line of pixel fields through the back conversion
   always_comb begin
      for (int i = 0; i < rhr_pkg::CAR_LEN; i++) begin
         car_in[i] = car_ff[(i == 0) ? 0 : i - 1];
      end
      car_in[0].r    = pix_ff[rhr_pkg::DIV_BITS].r;
      car_in[0].g    = pix_ff[rhr_pkg::DIV_BITS].g;
      car_in[0].b    = pix_ff[rhr_pkg::DIV_BITS].b;
      car_in[0].mx   = pix_ff[rhr_pkg::DIV_BITS].mx;
      car_in[0].gray = pix_ff[rhr_pkg::DIV_BITS].gray;
      car_in[0].sat  = sq;
      car_in[0].sec  = 3'd0;
      car_in[4].sec  = sec_in;
   end

   // stage 19: pick channels by sector
   logic [7:0] ro_ff, go_ff, bo_ff, ro_in, go_in, bo_in;
   rhr_pkg::car_type cl;

   always_comb begin
      cl = car_ff[rhr_pkg::CAR_LEN - 1];
      if (cl.gray) begin
         ro_in = cl.r;
         go_in = cl.g;
         bo_in = cl.b;
      end else begin
         case (cl.sec)
            3'd0: begin ro_in = cl.mx; go_in = tv; bo_in = pv; end
            3'd1: begin ro_in = qv; go_in = cl.mx; bo_in = pv; end
            3'd2: begin ro_in = pv; go_in = cl.mx; bo_in = tv; end
            3'd3: begin ro_in = pv; go_in = qv; bo_in = cl.mx; end
            3'd4: begin ro_in = tv; go_in = pv; bo_in = cl.mx; end
            default: begin ro_in = cl.mx; go_in = pv; bo_in = qv; end
         endcase
      end
   end

   // advance when the last stage is empty or being taken
   assign en        = !vld_ff[L - 1] || rsp.ready;
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < L; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req.valid;
         for (int i = 1; i < L; i++) vld_ff[i] <= vld_ff[i - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pix_ff[0] <= pix_in;
         for (int i = 1; i <= rhr_pkg::DIV_BITS; i++) pix_ff[i] <= pix_ff[i - 1];
         hnum_ff   <= hnum_in;
         hnum_d_ff <= d;
         snum_ff   <= snum_in;
         hsum_ff   <= hsum_in;
         hsum10_ff <= hsum_ff;
         hsum11_ff <= hsum10_ff;
         hprod_ff  <= hprod_in;
         hmul_ff   <= hmul_in;
         hue_ff    <= hue_in;
         frac_ff   <= frac_in;
         pk_ff     <= pk_in;
         qk_ff     <= qk_in;
         tk_ff     <= tk_in;
         px_ff     <= 22'(car_ff[5].mx) * 22'(pk_ff);
         qx_ff     <= 22'(car_ff[5].mx) * 22'(qk_ff);
         tx_ff     <= 22'(car_ff[5].mx) * 22'(tk_ff);
         for (int i = 0; i < rhr_pkg::CAR_LEN; i++) car_ff[i] <= car_in[i];
         ro_ff     <= ro_in;
         go_ff     <= go_in;
         bo_ff     <= bo_in;
      end
   end

   assign rsp.valid     = vld_ff[L - 1];
   assign rsp.red_out   = ro_ff;
   assign rsp.green_out = go_ff;
   assign rsp.blue_out  = bo_ff;

   // a waiting result blocks new input
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("input taken while result stalled");

   // held pipeline keeps its occupancy
   a_hold_vld: assert property (@(posedge clock) disable iff (reset)
      !en |=> vld_ff[L - 1] && $stable(vld_ff[L - 2]))
      else $error("pipeline moved while stalled");

   // reduced hue stays in range
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[12] |-> hue_ff < 9'd360)
      else $error("hue out of range");

   // sector is one of six
   a_sec_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[13] |-> car_ff[4].sec <= 3'd5)
      else $error("sector out of range");

endmodule
